// File: src/lalr_pkg.sv
// shared types and constants of the line average lamp regulator
// no dependencies; imported by every module of the block
`default_nettype none

package lalr_pkg;

    localparam int MAX_LINE_PIXELS  = 4096;
    localparam int MAX_ADJUST_LINES = 8;

    localparam int PIX_W  = 8;
    localparam int REF_W  = 16;
    localparam int TGT_W  = 8;
    localparam int IDX_W  = $clog2(MAX_LINE_PIXELS + 1);
    localparam int SUM_W  = $clog2(MAX_LINE_PIXELS * 255 + 1);
    localparam int LINE_W = $clog2(MAX_ADJUST_LINES + 1);
    localparam int BEG_W  = 12;
    localparam int END_W  = 13;
    localparam int CNT_W  = $clog2(SUM_W);

    localparam logic [TGT_W-1:0] BAND = 8'd5;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_TARGET    = 3'd0;
    localparam logic [2:0] REG_INIT_REF  = 3'd1;
    localparam logic [2:0] REG_MAX_REF   = 3'd2;
    localparam logic [2:0] REG_WIN_BEGIN = 3'd3;
    localparam logic [2:0] REG_WIN_END   = 3'd4;

    localparam logic [TGT_W-1:0] TARGET_RST    = 8'd128;
    localparam logic [REF_W-1:0] INIT_REF_RST  = 16'd0;
    localparam logic [REF_W-1:0] MAX_REF_RST   = 16'd2000;
    localparam logic [BEG_W-1:0] WIN_BEGIN_RST = 12'd300;
    localparam logic [END_W-1:0] WIN_END_RST   = 13'd3796;

    typedef struct packed {
        logic [TGT_W-1:0] target_level;
        logic [REF_W-1:0] initial_reference;
        logic [REF_W-1:0] max_reference;
        logic [BEG_W-1:0] window_begin;
        logic [END_W-1:0] window_end;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic line_end;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: src/lalr_cfg.sv
// apb register file holding the regulator configuration
// depends on lalr_pkg
`default_nettype none

module lalr_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lalr_pkg::ADDR_W-1:0] paddr,
    input  logic [lalr_pkg::DATA_W-1:0] pwdata,
    output logic [lalr_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output lalr_pkg::cfg_t            cfg
);
    import lalr_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level      <= TARGET_RST;
            cfg_reg.initial_reference <= INIT_REF_RST;
            cfg_reg.max_reference     <= MAX_REF_RST;
            cfg_reg.window_begin      <= WIN_BEGIN_RST;
            cfg_reg.window_end        <= WIN_END_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_TARGET:    cfg_reg.target_level      <= pwdata[TGT_W-1:0];
                REG_INIT_REF:  cfg_reg.initial_reference <= pwdata[REF_W-1:0];
                REG_MAX_REF:   cfg_reg.max_reference     <= pwdata[REF_W-1:0];
                REG_WIN_BEGIN: cfg_reg.window_begin      <= pwdata[BEG_W-1:0];
                REG_WIN_END:   cfg_reg.window_end        <= pwdata[END_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            REG_TARGET:    prdata[TGT_W-1:0] = cfg_reg.target_level;
            REG_INIT_REF:  prdata[REF_W-1:0] = cfg_reg.initial_reference;
            REG_MAX_REF:   prdata[REF_W-1:0] = cfg_reg.max_reference;
            REG_WIN_BEGIN: prdata[BEG_W-1:0] = cfg_reg.window_begin;
            REG_WIN_END:   prdata[END_W-1:0] = cfg_reg.window_end;
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: src/lalr_ctrl.sv
// controller: sequences pixel intake, the bit-serial divide and the line finish
// depends on lalr_pkg
`default_nettype none

module lalr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  lalr_pkg::sts_t sts,
    output lalr_pkg::cmd_t cmd
);
    import lalr_pkg::*;

    localparam logic [1:0] ST_PIXEL  = 2'd0;
    localparam logic [1:0] ST_DIVIDE = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_PIXEL;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.take     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.finish   = 1'b0;
        unique case (state_reg)
            ST_PIXEL:
            begin
                cmd.take = 1'b1;
                if (in_valid && sts.line_end)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait until the output register can take the line result
                cmd.finish = sts.out_free;
                if (sts.out_free)
                    state_next = ST_PIXEL;
            end
            default:
                state_next = ST_PIXEL;
        endcase
    end

`ifndef SYNTHESIS
    a_divide_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PIXEL && in_valid && sts.line_end) |=> (state_reg == ST_DIVIDE))
        else $error("line end not followed by divide");
    a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == ST_PIXEL))
        else $error("finish did not return to pixel intake");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !sts.div_last) |=> (state_reg == ST_DIVIDE))
        else $error("divide left early");
`endif

endmodule

`default_nettype wire

// File: src/lalr_dp.sv
// datapath: window accumulator, restoring divider, reference update, output register
// depends on lalr_pkg
`default_nettype none

module lalr_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lalr_pkg::cfg_t            cfg,
    input  lalr_pkg::cmd_t            cmd,
    output lalr_pkg::sts_t            sts,
    input  logic                      in_valid,
    input  logic [lalr_pkg::PIX_W-1:0]  pixel_value,
    input  logic                      line_last,
    input  logic                      run_start,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [lalr_pkg::PIX_W-1:0]  line_average,
    output logic [lalr_pkg::REF_W-1:0]  lamp_reference,
    output logic                      run_done,
    output logic                      within_band,
    output logic [lalr_pkg::LINE_W-1:0] line_number
);
    import lalr_pkg::*;

    // run state
    logic [IDX_W-1:0]  pixel_index_reg;
    logic [SUM_W-1:0]  window_sum_reg;
    logic [REF_W-1:0]  reference_reg;
    logic [LINE_W-1:0] line_count_reg;
    logic              finished_reg;

    // divider
    logic [SUM_W-1:0]  div_dq_reg;
    logic [END_W-1:0]  div_rem_reg;
    logic [END_W-1:0]  div_d_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic              avg_zero_reg;

    // output register
    logic              out_valid_reg;
    logic [PIX_W-1:0]  line_average_reg;
    logic [REF_W-1:0]  lamp_reference_reg;
    logic              run_done_reg;
    logic              within_band_reg;
    logic [LINE_W-1:0] line_number_reg;

    logic              pix_en;
    logic              active;
    logic [IDX_W-1:0]  idx_base;
    logic [SUM_W-1:0]  sum_base;
    logic              in_range;
    logic              in_win;
    logic [SUM_W-1:0]  sum_next;
    logic [IDX_W-1:0]  idx_next;
    logic [REF_W-1:0]  start_ref;

    logic [END_W:0]    trial;
    logic              trial_ge;
    logic [END_W-1:0]  rem_next;

    logic [PIX_W-1:0]  avg;
    logic              above;
    logic [PIX_W-1:0]  err;
    logic              in_band;
    logic [REF_W-1:0]  half;
    logic [REF_W:0]    ref_adj;
    logic [REF_W-1:0]  ref_clamped;
    logic              adjust;
    logic              done;
    logic [REF_W-1:0]  ref_new;

    assign pix_en   = in_valid && cmd.take;
    assign active   = run_start || !finished_reg;
    assign idx_base = run_start ? '0 : pixel_index_reg;
    assign sum_base = run_start ? '0 : window_sum_reg;
    assign in_range = idx_base < IDX_W'(MAX_LINE_PIXELS);
    assign in_win   = in_range && (idx_base >= {1'b0, cfg.window_begin})
                      && (idx_base < cfg.window_end);
    assign sum_next = sum_base + (in_win ? SUM_W'(pixel_value) : '0);
    assign idx_next = in_range ? idx_base + 1'b1 : idx_base;
    assign start_ref = (cfg.initial_reference > cfg.max_reference) ?
                       cfg.max_reference : cfg.initial_reference;

    // one quotient bit per cycle, msb first
    assign trial    = {div_rem_reg, div_dq_reg[SUM_W-1]};
    assign trial_ge = trial >= {1'b0, div_d_reg};
    assign rem_next = trial_ge ? END_W'(trial - {1'b0, div_d_reg}) : END_W'(trial);

    // line finish: error against target and reference move
    assign avg     = avg_zero_reg ? '0 : div_dq_reg[PIX_W-1:0];
    assign above   = avg > cfg.target_level;
    assign err     = above ? avg - cfg.target_level : cfg.target_level - avg;
    assign in_band = err <= BAND;
    assign half    = REF_W'(err[PIX_W-1:1]);
    assign ref_adj = above ? ((half > reference_reg) ? '0 : {1'b0, reference_reg - half})
                           : {1'b0, reference_reg} + {1'b0, half};
    assign ref_clamped = (ref_adj > {1'b0, cfg.max_reference}) ?
                         cfg.max_reference : ref_adj[REF_W-1:0];
    assign adjust  = !in_band && (line_count_reg != '0);
    assign done    = in_band || (adjust && line_count_reg >= LINE_W'(MAX_ADJUST_LINES));
    assign ref_new = adjust ? ref_clamped : reference_reg;

    assign sts.line_end = line_last && active;
    assign sts.div_last = div_cnt_reg == CNT_W'(SUM_W - 1);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_index_reg <= '0;
            window_sum_reg  <= '0;
            reference_reg   <= '0;
            line_count_reg  <= '0;
            finished_reg    <= 1'b1;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pix_en)
            begin
                if (run_start)
                begin
                    reference_reg  <= start_ref;
                    line_count_reg <= '0;
                    finished_reg   <= 1'b0;
                end
                if (active)
                begin
                    if (line_last)
                    begin
                        pixel_index_reg <= '0;
                        window_sum_reg  <= '0;
                        div_cnt_reg     <= '0;
                    end
                    else
                    begin
                        pixel_index_reg <= idx_next;
                        window_sum_reg  <= sum_next;
                    end
                end
            end
            if (cmd.div_step)
                div_cnt_reg <= sts.div_last ? '0 : div_cnt_reg + 1'b1;
            if (cmd.finish)
            begin
                reference_reg <= ref_new;
                finished_reg  <= done;
                if (!done)
                    line_count_reg <= line_count_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // divider operands and result payload
    always_ff @(posedge clk)
    begin
        if (pix_en && active && line_last)
        begin
            div_dq_reg   <= sum_next;
            div_rem_reg  <= '0;
            div_d_reg    <= END_W'(cfg.window_end - {1'b0, cfg.window_begin});
            avg_zero_reg <= !(cfg.window_end > {1'b0, cfg.window_begin});
        end
        else if (cmd.div_step)
        begin
            div_dq_reg  <= {div_dq_reg[SUM_W-2:0], trial_ge};
            div_rem_reg <= rem_next;
        end
        if (cmd.finish)
        begin
            line_average_reg   <= avg;
            lamp_reference_reg <= ref_new;
            run_done_reg       <= done;
            within_band_reg    <= in_band;
            line_number_reg    <= line_count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign line_average   = line_average_reg;
    assign lamp_reference = lamp_reference_reg;
    assign run_done       = run_done_reg;
    assign within_band    = within_band_reg;
    assign line_number    = line_number_reg;

`ifndef SYNTHESIS
    a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_en && sts.line_end) |=> (pixel_index_reg == '0 && window_sum_reg == '0))
        else $error("line state not cleared at line end");
    a_div_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && sts.div_last) |=> (div_cnt_reg == '0))
        else $error("divide counter did not wrap");
    a_done_matches: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (run_done_reg == finished_reg))
        else $error("run done flag disagrees with run state");
    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !finished_reg |-> (line_count_reg <= LINE_W'(MAX_ADJUST_LINES)))
        else $error("line count beyond adjustment limit");
`endif

endmodule

`default_nettype wire

// File: src/line_average_lamp_regulator.sv
// line average lamp regulator, top level: register file, controller and datapath
// depends on lalr_pkg, lalr_cfg, lalr_ctrl, lalr_dp
// throughput: one pixel per cycle within a line; a line-end pixel stalls input through the
//   bit-serial divide and the finish state, longer while the last result waits on m_tready
// output: the line result goes valid on m_tvalid once the divide and the finish state are through
// reset: asynchronous, active low; registers to defaults, no run active, output empty
`default_nettype none

module line_average_lamp_regulator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,  // [7:0] pixel_value
    input  logic                        s_tlast,  // line_last
    input  logic                        s_tuser,  // run_start
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,  // [7:0] line_average, [23:8] lamp_reference,
                                                  // [27:24] line_number, [31:28] zero
    output logic                        m_tlast,  // run_done
    output logic                        m_tuser,  // within_band
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lalr_pkg::ADDR_W-1:0] paddr,
    input  logic [lalr_pkg::DATA_W-1:0] pwdata,
    output logic [lalr_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import lalr_pkg::*;

    cfg_t              cfg;
    cmd_t              cmd;
    sts_t              sts;
    logic [PIX_W-1:0]  line_average;
    logic [REF_W-1:0]  lamp_reference;
    logic [LINE_W-1:0] line_number;

    lalr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lalr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    lalr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .in_valid       (s_tvalid),
        .pixel_value    (s_tdata),
        .line_last      (s_tlast),
        .run_start      (s_tuser),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .line_average   (line_average),
        .lamp_reference (lamp_reference),
        .run_done       (m_tlast),
        .within_band    (m_tuser),
        .line_number    (line_number)
    );

    assign s_tready = cmd.take;
    assign m_tdata  = {{(32 - PIX_W - REF_W - LINE_W){1'b0}},
                       line_number, lamp_reference, line_average};

endmodule

`default_nettype wire

// File: tb/sv/line_average_lamp_regulator_test.sv
// self-checking testbench for the line average lamp regulator: pixel lines in on the
// slave stream, line results checked on the master stream against an in-bench predictor
// depends on lalr_pkg and line_average_lamp_regulator
`default_nettype none

module line_average_lamp_regulator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lalr_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_WAIT  = 30;
    localparam int RANDOM_BEATS = 1150;
    localparam int MAX_REPORTS  = 40;

    // register slots past the end of the map, writes there must be dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [7:0]  pix;
        logic        last;
        logic        start;
        int unsigned gap;
    } pixel_beat_t;

    typedef struct packed {
        logic [7:0]  avg;
        logic [15:0] lamp;
        logic        done;
        logic        band;
        logic [3:0]  line;
    } line_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    line_average_lamp_regulator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the register file and of the regulator state
    cfg_t        shadow;
    int unsigned px_pos;
    int unsigned win_sum;
    logic [15:0] lamp_ref;
    logic [3:0]  adj_line;
    logic        no_run;

    pixel_beat_t  pixel_feed[$];
    line_result_t line_results_due[$];

    pixel_beat_t cur_beat;
    bit          have_cur = 1'b0;
    int unsigned gap_left = 0;
    bit          s_took = 1'b0;
    int unsigned stall_left = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned pixels_taken = 0;
    int unsigned results_checked = 0;
    int unsigned band_hits = 0;
    int unsigned runs_exhausted = 0;
    int unsigned settings_used = 0;
    int unsigned rand_items = 0;

    function automatic void predict_line_result(input logic [7:0] pix, input logic last,
                                                input logic start);
        line_result_t res;
        logic [7:0]   avg;
        logic [7:0]   err;
        int unsigned  stepped;
        logic         in_band;
        logic         done;
        if (start)
        begin
            lamp_ref = (shadow.initial_reference > shadow.max_reference) ?
                       shadow.max_reference : shadow.initial_reference;
            adj_line = '0;
            px_pos   = 0;
            win_sum  = 0;
            no_run   = 1'b0;
        end
        if (no_run)
            return;
        if (px_pos < MAX_LINE_PIXELS)
        begin
            if (px_pos >= shadow.window_begin && px_pos < shadow.window_end)
                win_sum += pix;
            px_pos++;
        end
        if (!last)
            return;
        avg = '0;
        if (shadow.window_end > shadow.window_begin)
            avg = 8'(win_sum / (shadow.window_end - shadow.window_begin));
        err = (avg > shadow.target_level) ? avg - shadow.target_level
                                          : shadow.target_level - avg;
        in_band = (err <= BAND);
        done = in_band;
        // the check line never moves the lamp
        if (!in_band && adj_line != 0)
        begin
            stepped = lamp_ref;
            if (avg > shadow.target_level)
                stepped = (err / 2 > stepped) ? 0 : stepped - err / 2;
            else
                stepped = stepped + err / 2;
            if (stepped > shadow.max_reference)
                stepped = shadow.max_reference;
            lamp_ref = 16'(stepped);
            if (adj_line >= MAX_ADJUST_LINES)
            begin
                done = 1'b1;
                runs_exhausted++;
            end
        end
        res = '{avg: avg, lamp: lamp_ref, done: done, band: in_band, line: adj_line};
        if (in_band)
            band_hits++;
        if (done)
            no_run = 1'b1;
        else
            adj_line = adj_line + 4'd1;
        px_pos  = 0;
        win_sum = 0;
        line_results_due.push_back(res);
    endfunction

    // pixel transaction accepted: advance the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            s_took = 1'b1;
            pixels_taken++;
            predict_line_result(s_tdata, s_tlast, s_tuser);
        end
    end

    // pixel driver
    always @(negedge clk)
    begin
        if (s_tvalid && s_took)
            have_cur = 1'b0;
        s_took = 1'b0;
        if (!have_cur && rst_n && pixel_feed.size() != 0)
        begin
            cur_beat = pixel_feed.pop_front();
            have_cur = 1'b1;
            gap_left = cur_beat.gap;
        end
        if (have_cur && gap_left == 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= cur_beat.pix;
            s_tlast  <= cur_beat.last;
            s_tuser  <= cur_beat.start;
        end
        else
        begin
            if (have_cur)
                gap_left--;
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            s_tuser  <= 1'($urandom);
        end
    end

    function automatic int unsigned pick_gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // result receiver back-pressure
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 99) < 25)
        begin
            stall_left = pick_gap_len() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // line result monitor
    always @(posedge clk)
    begin
        line_result_t got;
        line_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{avg: m_tdata[7:0], lamp: m_tdata[23:8], done: m_tlast,
                    band: m_tuser, line: m_tdata[27:24]};
            if (line_results_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected line result avg %0d lamp %0d done %0b band %0b line %0d",
                             $time, got.avg, got.lamp, got.done, got.band, got.line);
            end
            else
            begin
                exp_res = line_results_due.pop_front();
                results_checked++;
                if (got !== exp_res || m_tdata[31:28] !== 4'h0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t: line result: expected avg %0d lamp %0d done %0b band %0b",
                                  " line %0d, got avg %0d lamp %0d done %0b band %0b line %0d pad %h"},
                                 $time, exp_res.avg, exp_res.lamp, exp_res.done, exp_res.band,
                                 exp_res.line, got.avg, got.lamp, got.done, got.band, got.line,
                                 m_tdata[31:28]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d line results still due", cycles,
                     line_results_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_TARGET:    shadow.target_level      = data[7:0];
            REG_INIT_REF:  shadow.initial_reference = data[15:0];
            REG_MAX_REF:   shadow.max_reference     = data[15:0];
            REG_WIN_BEGIN: shadow.window_begin      = data[11:0];
            REG_WIN_END:   shadow.window_end        = data[12:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits of each write are junk and must be masked off by the block
    task automatic program_setting(input int t, input int init, input int top,
                                   input int b, input int e);
        apb_write(REG_TARGET,    {24'($urandom), 8'(t)});
        apb_write(REG_INIT_REF,  {16'($urandom), 16'(init)});
        apb_write(REG_MAX_REF,   {16'($urandom), 16'(top)});
        apb_write(REG_WIN_BEGIN, {20'($urandom), 12'(b)});
        apb_write(REG_WIN_END,   {19'($urandom), 13'(e)});
        settings_used++;
    endtask

    // waits until every queued pixel is sent and every due result is out, then lets the block settle
    task automatic wait_for_quiet();
        while (pixel_feed.size() != 0 || have_cur || line_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic push_beat(input logic [7:0] pix, input logic last, input logic start,
                             input bit counted);
        pixel_beat_t beat;
        beat.pix   = pix;
        beat.last  = last;
        beat.start = start;
        beat.gap   = (tx_idle_on && $urandom_range(0, 99) < 30) ? pick_gap_len() : 0;
        pixel_feed.push_back(beat);
        if (counted)
            rand_items++;
    endtask

    function automatic logic [7:0] near(input int level, input int spread);
        int v;
        v = level + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic int far_level();
        int t;
        t = shadow.target_level;
        if (t < 128)
            return t + 20 + int'($urandom_range(0, 100));
        return t - 20 - int'($urandom_range(0, 100));
    endfunction

    function automatic int line_len();
        int b;
        int e;
        b = shadow.window_begin;
        e = shadow.window_end;
        if (e > b && e <= 64)
        begin
            // some lines end before the window does
            if ($urandom_range(0, 9) == 0)
                return $urandom_range(1, e);
            return e + int'($urandom_range(0, 3));
        end
        return $urandom_range(1, 12);
    endfunction

    // level < 0 gives a line of fully random pixels
    task automatic queue_line(input int len, input bit run_head, input int level,
                              input int spread, input bit counted);
        int p;
        bit in_win;
        logic [7:0] v;
        logic st;
        for (p = 0; p < len; p++)
        begin
            in_win = (p >= shadow.window_begin && p < shadow.window_end);
            v = (in_win && level >= 0) ? near(level, spread) : 8'($urandom);
            st = (run_head && p == 0) || (counted && p > 0 && $urandom_range(0, 199) == 0);
            push_beat(v, p == len - 1, st, counted);
        end
    endtask

    // a run of far-off or fully random lines, the last one optionally landing in band
    task automatic queue_run(input int n_lines, input bit settle);
        int ln;
        for (ln = 0; ln < n_lines; ln++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_line(line_len(), ln == 0, -1, 0, 1'b1);
            else if (ln == n_lines - 1 && settle)
                queue_line(line_len(), ln == 0, shadow.target_level, 4, 1'b1);
            else
                queue_line(line_len(), ln == 0, far_level(), 8, 1'b1);
        end
    endtask

    task automatic queue_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            push_beat(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 19) == 0, 1'b0);
    endtask

    task automatic random_setting();
        int t;
        int init;
        int top;
        int b;
        int e;
        case ($urandom_range(0, 6))
            0:       t = $urandom_range(0, 7);
            1:       t = $urandom_range(248, 255);
            default: t = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 4))
            0, 1:    init = $urandom_range(0, 600);
            2:       init = 65535;
            default: init = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 19))
            0, 1:    top = 0;
            2, 3, 4: top = 65535;
            5, 6, 7: top = $urandom_range(0, 65535);
            default: top = $urandom_range(0, 600);
        endcase
        b = $urandom_range(0, 10);
        e = ($urandom_range(0, 99) < 85) ? b + int'($urandom_range(1, 24)) : $urandom_range(0, b);
        program_setting(t, init, top, b, e);
    endtask

    initial
    begin
        int k;
        int r;
        int n_runs;
        shadow = '{target_level: TARGET_RST, initial_reference: INIT_REF_RST,
                   max_reference: MAX_REF_RST, window_begin: WIN_BEGIN_RST,
                   window_end: WIN_END_RST};
        px_pos   = 0;
        win_sum  = 0;
        lamp_ref = '0;
        adj_line = '0;
        no_run   = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no run active after reset: both pixels are dropped
        push_beat(8'h5A, 1'b1, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        // one-pixel check line at reset settings, window not reached so average 0
        push_beat(8'hFF, 1'b1, 1'b1, 1'b0);
        wait_for_quiet();

        program_setting(255, 65535, 65535, 0, 2);
        push_beat(8'hFF, 1'b0, 1'b1, 1'b0);
        push_beat(8'hFF, 1'b1, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b1, 1'b0);
        push_beat(8'h00, 1'b1, 1'b0, 1'b0);
        // adjustment line saturates at the top of the lamp range
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h00, 1'b1, 1'b0, 1'b0);
        // restart in the middle of a line
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b1, 1'b0);
        push_beat(8'h00, 1'b1, 1'b0, 1'b0);
        wait_for_quiet();

        program_setting(0, 0, 0, 0, 1);
        push_beat(8'd200, 1'b0, 1'b1, 1'b0);
        push_beat(8'd0,   1'b1, 1'b0, 1'b0);
        // lamp step down saturates at zero
        push_beat(8'd200, 1'b1, 1'b0, 1'b0);
        push_beat(8'd3,   1'b1, 1'b0, 1'b0);
        wait_for_quiet();

        // empty then inverted window: average forced to zero
        program_setting(0, 10, 100, 5, 5);
        push_beat(8'd77, 1'b1, 1'b1, 1'b0);
        wait_for_quiet();
        program_setting(40, 10, 100, 9, 4);
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        push_beat(8'd1,   1'b0, 1'b1, 1'b0);
        push_beat(8'd250, 1'b1, 1'b0, 1'b0);
        wait_for_quiet();

        rand_items = 0;
        for (k = 0; k < 6 || rand_items < RANDOM_BEATS; k++)
        begin
            tx_idle_on = (k % 3 != 2);
            rx_idle_on = (k % 4 != 3);
            case (k)
                0: program_setting(0, 0, 0, 0, 4);
                1: program_setting(255, 65535, 65535, 3, 9);
                2: program_setting($urandom_range(0, 255), $urandom_range(0, 600), 600, 6, 6);
                3: program_setting($urandom_range(0, 255), 300, 65535, 10, 4);
                4:
                begin
                    // one overlong line across the last window position
                    tx_idle_on = 1'b0;
                    program_setting($urandom_range(0, 255), $urandom_range(0, 65535),
                                    65535, MAX_LINE_PIXELS - 1, MAX_LINE_PIXELS);
                    queue_line(MAX_LINE_PIXELS + 4, 1'b1, far_level(), 8, 1'b0);
                    queue_line(3, 1'b0, -1, 0, 1'b0);
                end
                default: random_setting();
            endcase
            if ($urandom_range(0, 2) == 0)
                apb_write(REG_SPARE_HI, $urandom);
            if (k != 4)
            begin
                n_runs = $urandom_range(3, 6);
                for (r = 0; r < n_runs; r++)
                begin
                    if ($urandom_range(0, 99) < 12)
                        queue_noise($urandom_range(4, 20));
                    else if ($urandom_range(0, 2) == 0)
                        queue_run(MAX_ADJUST_LINES + 1, 1'b0);
                    else
                        queue_run($urandom_range(1, MAX_ADJUST_LINES + 1), $urandom_range(0, 1));
                end
            end
            wait_for_quiet();
        end

        $display("covered %0d pixel transactions and %0d line results over %0d register settings",
                 pixels_taken, results_checked, settings_used);
        $display("%0d lines landed in band, %0d runs used every adjustment line",
                 band_hits, runs_exhausted);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
